FILE: src/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and fixed constants of the complex moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

  // Width of the window length register and its value after reset
  localparam int unsigned REG_W = 9;
  localparam logic [REG_W-1:0] LENGTH_RESET = 9'd8;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } cma_state_t;

endpackage

FILE: src/cma_sample_if.sv
// ----------------------------------------------------------------------------
// cma_sample_if
// Valid/ready channel that carries one complex input sample per item.
// ----------------------------------------------------------------------------
interface cma_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_re;
  logic signed [SAMPLE_WIDTH-1:0] sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

FILE: src/cma_avg_if.sv
// ----------------------------------------------------------------------------
// cma_avg_if
// Valid/ready channel that carries one complex window average per item.
// ----------------------------------------------------------------------------
interface cma_avg_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] avg_re;
  logic signed [SAMPLE_WIDTH-1:0] avg_im;

  modport source (output valid, output avg_re, output avg_im, input ready);
  modport sink   (input valid, input avg_re, input avg_im, output ready);
endinterface

FILE: src/complex_moving_average.sv
// ----------------------------------------------------------------------------
// complex_moving_average
// Moving average over a window of complex samples, ring store in RAM.
// ----------------------------------------------------------------------------
// The block keeps the last window_length samples in a RAM ring. After a reset
// or a write of window_length, the first window_length items only fill the
// window and give no result. Every later item reads the oldest slot, updates
// both running sums and overwrites the slot, divides both sums by the window
// length in a restoring divider that settles one quotient bit a cycle, and
// loads the output register once that register is free. No new sample is
// taken until then. The output register lets the next item enter while a
// result still waits to be taken. A window length of zero acts as one; one
// above MAX_WINDOW acts as MAX_WINDOW. Averages are truncated toward zero.
module complex_moving_average #(
  parameter int MAX_WINDOW   = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cma_pkg::REG_W-1:0] cfg_data,
  cma_sample_if.sink                sample,
  cma_avg_if.source                 average
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (LEN_W > cma_pkg::REG_W) ? LEN_W : cma_pkg::REG_W;
  localparam int SUM_W = SAMPLE_WIDTH + LEN_W + 1;
  localparam int RW    = LEN_W + 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  cma_pkg::cma_state_t state;

  logic [cma_pkg::REG_W-1:0]        window_length;
  logic [AW-1:0]                    write_slot;
  logic [LEN_W-1:0]                 fill_count;
  logic signed [SUM_W-1:0]          sum      [2];
  logic signed [SAMPLE_WIDTH-1:0]   samp_hold [2];
  logic [AW-1:0]                    slot_hold;
  logic [SUM_W-1:0]                 div_mag  [2];
  logic [RW-1:0]                    div_rem  [2];
  logic                             div_neg  [2];
  logic [LEN_W-1:0]                 div_len;
  logic [CNT_W-1:0]                 div_count;
  logic                             out_valid;
  logic signed [SAMPLE_WIDTH-1:0]   out_res  [2];

  logic [CMP_W-1:0]                 wl_ext;
  logic [LEN_W-1:0]                 len_eff;
  logic [AW-1:0]                    slot_cur;
  logic [AW-1:0]                    slot_base;
  logic [LEN_W-1:0]                 slot_inc;
  logic [AW-1:0]                    slot_next;
  logic                             accept;
  logic                             filling;
  logic                             out_free;
  logic signed [SAMPLE_WIDTH-1:0]   samp_in  [2];
  logic signed [SAMPLE_WIDTH-1:0]   old_samp [2];
  logic signed [SUM_W-1:0]          sum_upd  [2];
  logic [SUM_W-1:0]                 mag_ld   [2];
  logic [RW-1:0]                    trial    [2];
  logic                             fits     [2];
  logic [SUM_W-1:0]                 quot     [2];

  logic                             ram_we;
  logic                             ram_re;
  logic [AW-1:0]                    ram_waddr;
  logic [2*SAMPLE_WIDTH-1:0]        ram_wdata;
  logic [2*SAMPLE_WIDTH-1:0]        ram_rdata;

  // Clamp the window length to 1..MAX_WINDOW
  always_comb begin
    wl_ext = CMP_W'(window_length);
    if (wl_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(wl_ext);
    end
  end

  // Slot arithmetic: current slot, and the one after the slot being written
  always_comb begin
    slot_cur  = (LEN_W'(write_slot) >= len_eff) ? '0 : write_slot;
    slot_base = (state == cma_pkg::S_READ) ? slot_hold : slot_cur;
    slot_inc  = LEN_W'(slot_base) + LEN_W'(1);
    slot_next = (slot_inc >= len_eff) ? '0 : slot_inc[AW-1:0];
  end

  assign accept   = sample.valid && sample.ready;
  assign filling  = fill_count < len_eff;
  assign out_free = !out_valid || average.ready;

  assign samp_in[0]  = sample.sample_re;
  assign samp_in[1]  = sample.sample_im;
  assign old_samp[0] = ram_rdata[SAMPLE_WIDTH-1:0];
  assign old_samp[1] = ram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

  // Per-part sum update, divider load value, divider step and final sign
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sum_upd[i] = sum[i] + SUM_W'(samp_hold[i]) - SUM_W'(old_samp[i]);
      mag_ld[i]  = sum_upd[i][SUM_W-1] ? SUM_W'(-sum_upd[i]) : SUM_W'(sum_upd[i]);
      trial[i]   = {div_rem[i][LEN_W-1:0], div_mag[i][SUM_W-1]};
      fits[i]    = trial[i] >= RW'(div_len);
      quot[i]    = div_neg[i] ? SUM_W'(-div_mag[i]) : div_mag[i];
    end
  end

  // Ring store port control: fill writes straight from the input
  always_comb begin
    ram_re    = accept && !filling;
    ram_we    = (accept && filling) || (state == cma_pkg::S_READ);
    ram_waddr = slot_base;
    if (state == cma_pkg::S_READ) begin
      ram_wdata = {samp_hold[1], samp_hold[0]};
    end else begin
      ram_wdata = {samp_in[1], samp_in[0]};
    end
  end

  cma_ram #(
    .WIDTH (2 * SAMPLE_WIDTH),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_cur),
    .rdata (ram_rdata)
  );

  // Sequencer, running sums and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cma_pkg::S_IDLE;
      window_length <= cma_pkg::LENGTH_RESET;
      write_slot    <= '0;
      fill_count    <= '0;
      sum[0]        <= '0;
      sum[1]        <= '0;
      div_count     <= '0;
    end else begin
      unique case (state)
        cma_pkg::S_IDLE: begin
          if (accept) begin
            samp_hold[0] <= samp_in[0];
            samp_hold[1] <= samp_in[1];
            slot_hold    <= slot_cur;
            if (filling) begin
              sum[0]     <= sum[0] + SUM_W'(samp_in[0]);
              sum[1]     <= sum[1] + SUM_W'(samp_in[1]);
              fill_count <= fill_count + LEN_W'(1);
              write_slot <= slot_next;
            end else begin
              state <= cma_pkg::S_READ;
            end
          end
        end
        cma_pkg::S_READ: begin
          // Swap the oldest sample for the new one, then start dividing
          for (int i = 0; i < 2; i++) begin
            sum[i]     <= sum_upd[i];
            div_mag[i] <= mag_ld[i];
            div_neg[i] <= sum_upd[i][SUM_W-1];
            div_rem[i] <= '0;
          end
          div_len    <= len_eff;
          div_count  <= CNT_W'(SUM_W);
          write_slot <= slot_next;
          state      <= cma_pkg::S_DIV;
        end
        cma_pkg::S_DIV: begin
          // Settle one quotient bit of each part
          for (int i = 0; i < 2; i++) begin
            div_rem[i] <= fits[i] ? (trial[i] - RW'(div_len)) : trial[i];
            div_mag[i] <= {div_mag[i][SUM_W-2:0], fits[i]};
          end
          div_count <= div_count - CNT_W'(1);
          if (div_count == CNT_W'(1)) begin
            state <= cma_pkg::S_DONE;
          end
        end
        cma_pkg::S_DONE: begin
          if (out_free) begin
            state <= cma_pkg::S_IDLE;
          end
        end
        default: state <= cma_pkg::S_IDLE;
      endcase

      // Restart the fill phase on a register write
      if (cfg_we) begin
        window_length <= cfg_data;
        write_slot    <= '0;
        fill_count    <= '0;
        sum[0]        <= '0;
        sum[1]        <= '0;
      end
    end
  end

  // Output register: load when the divider is done and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cma_pkg::S_DONE && out_free) begin
      out_valid  <= 1'b1;
      out_res[0] <= quot[0][SAMPLE_WIDTH-1:0];
      out_res[1] <= quot[1][SAMPLE_WIDTH-1:0];
    end else if (average.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sample.ready   = (state == cma_pkg::S_IDLE);
  assign average.valid  = out_valid;
  assign average.avg_re = out_res[0];
  assign average.avg_im = out_res[1];

`ifndef SYNTH
  // An item taken during the fill phase never starts the averaging path
  a_fill_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && filling) |=> (state == cma_pkg::S_IDLE))
    else $error("fill-phase item left the idle state");

  // A result appears only after the divider has finished
  a_result_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == cma_pkg::S_DONE))
    else $error("result loaded without a finished division");

  // The write slot always lies inside the window
  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(write_slot) < len_eff)
    else $error("write slot outside the window");

  // The divider remainder ends below the divisor
  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == cma_pkg::S_DONE) |-> (div_rem[0] < RW'(div_len) && div_rem[1] < RW'(div_len)))
    else $error("divider remainder not below the window length");
`endif

endmodule

FILE: src/cma_ram.sv
// ----------------------------------------------------------------------------
// cma_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
